FILE: sv/mss_pkg.sv
// Markov sequence sampler: shared constants, mode codes, controller states
// and the command/status structs between controller and datapath.
// No dependencies.
package mss_pkg;

  localparam int ORDER       = 3;
  localparam int NUM_ENTRIES = 256;
  localparam int MAX_NEXT    = 16;
  localparam int SYMBOL_BITS = 8;

  localparam int ENTRY_W   = $clog2(NUM_ENTRIES);
  localparam int ENT_CMP_W = ((ENTRY_W > 8) ? ENTRY_W : 8) + 1;
  localparam int SYM_W     = SYMBOL_BITS;
  localparam int WEIGHT_W  = 16;
  localparam int RND_W     = 16;
  localparam int CNT_W     = $clog2(MAX_NEXT + 1);
  localparam int SLOTS     = NUM_ENTRIES * MAX_NEXT;
  localparam int SADDR_W   = $clog2(SLOTS);
  localparam int TOT_W     = 20;
  localparam int STATS_W   = CNT_W + TOT_W;
  localparam int TGT_W     = RND_W + TOT_W;
  localparam int CUM_W     = WEIGHT_W + CNT_W;
  localparam int CMP_W     = ((CUM_W + RND_W) > TGT_W) ? (CUM_W + RND_W) : TGT_W;
  localparam int POS_CMP_W = 8;

  localparam logic [TOT_W-1:0]   TOTAL_MAX  = '1;
  localparam logic [ENTRY_W-1:0] LAST_ENTRY = ENTRY_W'(NUM_ENTRIES - 1);

  localparam int S_TDATA_W = 56;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 24;
  localparam int M_TUSER_W = 1;

  typedef enum logic [1:0] {
    MODE_LOAD_HIST = 2'd0,
    MODE_LOAD_SLOT = 2'd1,
    MODE_SET       = 2'd2,
    MODE_STEP      = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SLOT_WR,
    ST_STEP_MUL,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SEARCH,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic capture;
    logic hist_wr;
    logic slot_wr;
    logic set_cur;
    logic step_mul;
    logic scan_chk;
    logic srch_init;
    logic srch_run;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  ent_ok;
    logic  hist_pos_ok;
    logic  slot_pos_ok;
    logic  cur_valid;
    logic  n_zero;
    logic  scan_hit;
    logic  scan_last;
    logic  srch_found;
    logic  srch_done;
    logic  out_free;
  } dp_sts_t;

endpackage

FILE: sv/mss_ctrl.sv
// Markov sequence sampler controller: sequences load, set and step items.
// Depends on mss_pkg (state_e, dp_cmd_t, dp_sts_t).
module mss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  mss_pkg::dp_sts_t sts_i,
  output mss_pkg::dp_cmd_t cmd_o
);

  mss_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mss_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      mss_pkg::ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = mss_pkg::ST_DECODE;
        end
      end
      mss_pkg::ST_DECODE: begin
        state_d = mss_pkg::ST_RESULT;
        case (sts_i.mode)
          mss_pkg::MODE_LOAD_HIST: cmd_o.hist_wr = sts_i.ent_ok && sts_i.hist_pos_ok;
          mss_pkg::MODE_LOAD_SLOT: begin
            if (sts_i.ent_ok && sts_i.slot_pos_ok) state_d = mss_pkg::ST_SLOT_WR;
          end
          mss_pkg::MODE_SET: cmd_o.set_cur = sts_i.ent_ok;
          mss_pkg::MODE_STEP: begin
            if (sts_i.cur_valid) state_d = mss_pkg::ST_STEP_MUL;
          end
          default: state_d = mss_pkg::ST_RESULT;
        endcase
      end
      mss_pkg::ST_SLOT_WR: begin
        cmd_o.slot_wr = 1'b1;
        state_d       = mss_pkg::ST_RESULT;
      end
      mss_pkg::ST_STEP_MUL: begin
        cmd_o.step_mul = 1'b1;
        state_d        = sts_i.n_zero ? mss_pkg::ST_RESULT : mss_pkg::ST_SCAN_RD;
      end
      mss_pkg::ST_SCAN_RD: begin
        state_d = mss_pkg::ST_SCAN_CHK;
      end
      mss_pkg::ST_SCAN_CHK: begin
        cmd_o.scan_chk = 1'b1;
        if (sts_i.scan_hit) begin
          cmd_o.srch_init = 1'b1;
          state_d         = mss_pkg::ST_SEARCH;
        end else if (sts_i.scan_last) begin
          state_d = mss_pkg::ST_RESULT;
        end else begin
          state_d = mss_pkg::ST_SCAN_RD;
        end
      end
      mss_pkg::ST_SEARCH: begin
        cmd_o.srch_run = 1'b1;
        if (sts_i.srch_found || sts_i.srch_done) state_d = mss_pkg::ST_RESULT;
      end
      mss_pkg::ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = mss_pkg::ST_IDLE;
        end
      end
      default: state_d = mss_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: sv/mss_dp.sv
// Markov sequence sampler datapath: history, slot and statistics memories,
// weighted slot scan, successor search and the output register.
// Depends on mss_pkg.
module mss_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [mss_pkg::S_TDATA_W-1:0]    s_tdata_i,
  input  logic [mss_pkg::S_TUSER_W-1:0]    s_tuser_i,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  output logic [mss_pkg::M_TDATA_W-1:0]    m_tdata_o,
  output logic [mss_pkg::M_TUSER_W-1:0]    m_tuser_o,
  input  mss_pkg::dp_cmd_t                 cmd_i,
  output mss_pkg::dp_sts_t                 sts_o
);

  // captured item
  mss_pkg::mode_e                 mode_q;
  logic [7:0]                     entry_q;
  logic [3:0]                     pos_q;
  logic [mss_pkg::SYM_W-1:0]      sym_q;
  logic [mss_pkg::WEIGHT_W-1:0]   weight_q;
  logic [mss_pkg::RND_W-1:0]      rnd_q;

  logic [mss_pkg::ENTRY_W-1:0]    cur_q;
  logic [mss_pkg::NUM_ENTRIES-1:0] ent_vld_q;
  logic [mss_pkg::NUM_ENTRIES-1:0] stats_vld_q;

  logic [mss_pkg::ENT_CMP_W-1:0]  ent_ext;
  logic [mss_pkg::ENTRY_W-1:0]    ent_idx;
  logic                           ent_ok;

  // step working registers
  logic [mss_pkg::CNT_W-1:0]      n_q;
  logic [mss_pkg::TGT_W-1:0]      target_q;
  logic [mss_pkg::CNT_W-1:0]      slot_idx_q;
  logic [mss_pkg::CUM_W-1:0]      cum_q;
  logic [mss_pkg::CUM_W-1:0]      cum_nx;
  logic                           produced_q;
  logic                           advanced_q;
  logic [mss_pkg::SYM_W-1:0]      nsym_q;
  logic [mss_pkg::SYM_W-1:0]      cur_hist_q [mss_pkg::ORDER];

  // successor search
  logic [mss_pkg::ENTRY_W-1:0]    srch_idx_q;
  logic                           srch_more_q;
  logic                           chk_vld_q;
  logic [mss_pkg::ENTRY_W-1:0]    chk_idx_q;
  logic                           hist_eq;

  // memories
  logic [mss_pkg::ENTRY_W-1:0]    hist_raddr;
  logic [mss_pkg::SYM_W-1:0]      hist_rd [mss_pkg::ORDER];

  logic [mss_pkg::STATS_W-1:0]    stats_mem [mss_pkg::NUM_ENTRIES];
  logic [mss_pkg::STATS_W-1:0]    stats_rd_q;
  logic                           stats_rvld_q;
  logic [mss_pkg::ENTRY_W-1:0]    stats_raddr;
  logic [mss_pkg::CNT_W-1:0]      old_cnt;
  logic [mss_pkg::TOT_W-1:0]      old_tot;
  logic [mss_pkg::CNT_W-1:0]      new_cnt;
  logic [mss_pkg::CNT_W-1:0]      pos_cnt;
  logic [mss_pkg::TOT_W:0]        tot_sum;
  logic [mss_pkg::TOT_W-1:0]      new_tot;

  logic [mss_pkg::SYM_W+mss_pkg::WEIGHT_W-1:0] slot_mem [mss_pkg::SLOTS];
  logic [mss_pkg::SYM_W+mss_pkg::WEIGHT_W-1:0] slot_rd_q;
  logic [mss_pkg::SADDR_W-1:0]    slot_waddr;
  logic [mss_pkg::SADDR_W-1:0]    slot_raddr;
  logic [mss_pkg::SYM_W-1:0]      slot_sym;
  logic [mss_pkg::WEIGHT_W-1:0]   slot_w;

  logic                           m_tvalid_q;
  logic [mss_pkg::M_TDATA_W-1:0]  m_tdata_q;
  logic [mss_pkg::M_TUSER_W-1:0]  m_tuser_q;

  assign ent_ext = mss_pkg::ENT_CMP_W'(entry_q);
  assign ent_idx = ent_ext[mss_pkg::ENTRY_W-1:0];
  assign ent_ok  = ent_ext < mss_pkg::ENT_CMP_W'(mss_pkg::NUM_ENTRIES);

  // ---------------------------------------------------------------- item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q   <= mss_pkg::mode_e'(s_tuser_i);
      entry_q  <= s_tdata_i[7:0];
      pos_q    <= s_tdata_i[11:8];
      sym_q    <= mss_pkg::SYM_W'(s_tdata_i[19:12]);
      weight_q <= s_tdata_i[35:20];
      rnd_q    <= s_tdata_i[51:36];
    end
  end

  // ---------------------------------------------------------------- history
  assign hist_raddr = cmd_i.srch_run ? srch_idx_q : cur_q;

  for (genvar k = 0; k < mss_pkg::ORDER; k++) begin : g_hist
    logic [mss_pkg::SYM_W-1:0] mem [mss_pkg::NUM_ENTRIES];
    logic [mss_pkg::SYM_W-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (cmd_i.hist_wr && (pos_q == 4'(k))) begin
        mem[ent_idx] <= sym_q;
      end
      rd_q <= mem[hist_raddr];
    end
    assign hist_rd[k] = rd_q;
  end

  // candidate history must equal current history shifted, plus new symbol
  always_comb begin
    hist_eq = (hist_rd[mss_pkg::ORDER-1] == nsym_q);
    for (int i = 0; i < mss_pkg::ORDER - 1; i++) begin
      if (hist_rd[i] != cur_hist_q[i+1]) hist_eq = 1'b0;
    end
  end

  // ---------------------------------------------------------------- stats
  assign stats_raddr = (mode_q == mss_pkg::MODE_STEP) ? cur_q : ent_idx;
  assign old_cnt = stats_rvld_q ? stats_rd_q[mss_pkg::STATS_W-1:mss_pkg::TOT_W] : '0;
  assign old_tot = stats_rvld_q ? stats_rd_q[mss_pkg::TOT_W-1:0] : '0;
  assign pos_cnt = mss_pkg::CNT_W'(pos_q) + mss_pkg::CNT_W'(1);
  assign new_cnt = (old_cnt < pos_cnt) ? pos_cnt : old_cnt;
  assign tot_sum = {1'b0, old_tot} + (mss_pkg::TOT_W+1)'(weight_q);
  assign new_tot = tot_sum[mss_pkg::TOT_W] ? mss_pkg::TOTAL_MAX : tot_sum[mss_pkg::TOT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.slot_wr) begin
      stats_mem[ent_idx] <= {new_cnt, new_tot};
    end
    stats_rd_q   <= stats_mem[stats_raddr];
    stats_rvld_q <= stats_vld_q[stats_raddr];
  end

  // ---------------------------------------------------------------- slots
  assign slot_waddr = mss_pkg::SADDR_W'(mss_pkg::SADDR_W'(ent_idx)
                      * mss_pkg::SADDR_W'(mss_pkg::MAX_NEXT) + mss_pkg::SADDR_W'(pos_q));
  assign slot_raddr = mss_pkg::SADDR_W'(mss_pkg::SADDR_W'(cur_q)
                      * mss_pkg::SADDR_W'(mss_pkg::MAX_NEXT) + mss_pkg::SADDR_W'(slot_idx_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.slot_wr) begin
      slot_mem[slot_waddr] <= {sym_q, weight_q};
    end
    slot_rd_q <= slot_mem[slot_raddr];
  end

  assign slot_sym = slot_rd_q[mss_pkg::SYM_W+mss_pkg::WEIGHT_W-1:mss_pkg::WEIGHT_W];
  assign slot_w   = slot_rd_q[mss_pkg::WEIGHT_W-1:0];
  assign cum_nx   = cum_q + mss_pkg::CUM_W'(slot_w);

  // ---------------------------------------------------------------- step
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      produced_q <= 1'b0;
      advanced_q <= 1'b0;
      nsym_q     <= '0;
    end
    if (cmd_i.step_mul) begin
      n_q        <= old_cnt;
      target_q   <= mss_pkg::TGT_W'(rnd_q) * mss_pkg::TGT_W'(old_tot);
      slot_idx_q <= '0;
      cum_q      <= '0;
      cur_hist_q <= hist_rd;
    end
    if (cmd_i.scan_chk) begin
      cum_q      <= cum_nx;
      slot_idx_q <= slot_idx_q + mss_pkg::CNT_W'(1);
      if (sts_o.scan_hit) begin
        produced_q <= 1'b1;
        nsym_q     <= slot_sym;
      end
    end
    if (cmd_i.srch_run && sts_o.srch_found) begin
      advanced_q <= 1'b1;
    end
    if (cmd_i.srch_run) begin
      chk_idx_q <= srch_idx_q;
    end
    if (cmd_i.srch_init) begin
      srch_idx_q <= '0;
    end else if (cmd_i.srch_run && srch_more_q && (srch_idx_q != mss_pkg::LAST_ENTRY)) begin
      srch_idx_q <= srch_idx_q + mss_pkg::ENTRY_W'(1);
    end
  end

  // ---------------------------------------------------------------- control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      ent_vld_q   <= '0;
      stats_vld_q <= '0;
      srch_more_q <= 1'b0;
      chk_vld_q   <= 1'b0;
      m_tvalid_q  <= 1'b0;
    end else begin
      if (cmd_i.hist_wr) ent_vld_q[ent_idx] <= 1'b1;
      if (cmd_i.slot_wr) stats_vld_q[ent_idx] <= 1'b1;
      if (cmd_i.set_cur) begin
        cur_q <= ent_idx;
      end else if (cmd_i.srch_run && sts_o.srch_found) begin
        cur_q <= chk_idx_q;
      end
      if (cmd_i.srch_init) begin
        srch_more_q <= 1'b1;
      end else if (cmd_i.srch_run && (srch_idx_q == mss_pkg::LAST_ENTRY)) begin
        srch_more_q <= 1'b0;
      end
      chk_vld_q <= cmd_i.srch_run && srch_more_q;
      if (cmd_i.out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      m_tdata_q <= {7'd0, 8'(cur_q), advanced_q, 8'(nsym_q)};
      m_tuser_q <= produced_q;
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tuser_o  = m_tuser_q;

  // ---------------------------------------------------------------- status
  always_comb begin
    sts_o.mode        = mode_q;
    sts_o.ent_ok      = ent_ok;
    sts_o.hist_pos_ok = mss_pkg::POS_CMP_W'(pos_q) < mss_pkg::POS_CMP_W'(mss_pkg::ORDER);
    sts_o.slot_pos_ok = mss_pkg::POS_CMP_W'(pos_q) < mss_pkg::POS_CMP_W'(mss_pkg::MAX_NEXT);
    sts_o.cur_valid   = ent_vld_q[cur_q];
    sts_o.n_zero      = (old_cnt == '0);
    // (cum + slot weight) * 65536 >= random * total
    sts_o.scan_hit    = mss_pkg::CMP_W'({cum_nx, 16'h0000}) >= mss_pkg::CMP_W'(target_q);
    sts_o.scan_last   = (slot_idx_q + mss_pkg::CNT_W'(1)) == n_q;
    sts_o.srch_found  = chk_vld_q && ent_vld_q[chk_idx_q] && hist_eq;
    sts_o.srch_done   = chk_vld_q && (chk_idx_q == mss_pkg::LAST_ENTRY);
    sts_o.out_free    = !m_tvalid_q || m_tready_i;
  end

endmodule

FILE: sv/markov_sequence_sampler_unit.sv
// Markov sequence sampler top level: stream ports, controller and datapath.
// Depends on mss_pkg, mss_ctrl, mss_dp.
//
// Order-3 Markov chain sampler over a 256-entry table. Each input beat on the
// s_ channel carries one item; tuser selects load history, load slot, set
// current entry or step. Every item returns exactly one result beat on the
// m_ channel: produced (tuser), next symbol, advanced and current entry.
// One item is in work at a time; s_tready is high only while idle.
// A step walks the slots of the current entry one at a time, through the
// single slot-memory read port, and, when a slot is picked, searches the
// entries for the successor with one history read per entry examined; no
// search is made when no slot is picked.
// Reset clears entry valid bits, slot counts and totals, and the current
// entry; history and slot memories hold garbage until loaded.
// A stalled receiver holds the result in the output register; the next item
// may still be accepted and worked on, and waits for the register to drain.
module markov_sequence_sampler_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // [7:0] entry, [11:8] position, [19:12] symbol, [35:20] weight,
  // [51:36] random, [55:52] zero
  input  logic [mss_pkg::S_TDATA_W-1:0] s_tdata_i,
  // [1:0] mode
  input  logic [mss_pkg::S_TUSER_W-1:0] s_tuser_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // [7:0] next_symbol, [8] advanced, [16:9] current, [23:17] zero
  output logic [mss_pkg::M_TDATA_W-1:0] m_tdata_o,
  // [0] produced
  output logic [mss_pkg::M_TUSER_W-1:0] m_tuser_o
);

  mss_pkg::dp_cmd_t cmd;
  mss_pkg::dp_sts_t sts;

  mss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mss_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

FILE: sv/mss_chk.sv
// Markov sequence sampler port checker, bound to the top level.
// Depends on mss_pkg for port widths.
module mss_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_tvalid_i,
  input logic                          s_tready_o,
  input logic [mss_pkg::S_TDATA_W-1:0] s_tdata_i,
  input logic [mss_pkg::S_TUSER_W-1:0] s_tuser_i,
  input logic                          m_tvalid_o,
  input logic                          m_tready_i,
  input logic [mss_pkg::M_TDATA_W-1:0] m_tdata_o,
  input logic [mss_pkg::M_TUSER_W-1:0] m_tuser_o
);

  // one item at a time: no accept on the beat after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> !s_tready_o)
    else $error("input accepted twice in a row");

  // no symbol sampled means no symbol reported and no move
  a_quiet_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && (m_tuser_o == 1'b0)) |-> (m_tdata_o[8:0] == 9'd0))
    else $error("symbol or advance flagged without a produced symbol");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> m_tvalid_o)
    else $error("result beat dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> ($stable(m_tdata_o) && $stable(m_tuser_o)))
    else $error("result beat changed while stalled");

endmodule

bind markov_sequence_sampler_unit mss_chk u_mss_chk (.*);
